// ===== rtl/activity_selection_greedy_macros.svh =====
// Assertion macros used by the checker file of the activity selection block.
`ifndef ACTIVITY_SELECTION_GREEDY_MACROS_SVH
`define ACTIVITY_SELECTION_GREEDY_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ASG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/asg_pkg.sv =====
// Shared types and constants of the greedy activity selection block.
package asg_pkg;

    // Fixed widths of the channel fields.
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 7;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // One activity as it travels from the front to the back.
    typedef struct packed {
        logic               keep;
        logic               last;
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] start_time;
        logic [FIELD_W-1:0] end_time;
    } asg_item_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_LOAD,
        BK_SCAN,
        BK_FLUSH,
        BK_DECIDE,
        BK_EMIT_RD,
        BK_EMIT_LD,
        BK_EMIT_HOLD
    } asg_back_state_t;

endpackage

// ===== rtl/asg_front.sv =====
// Input front end: accepts activities and marks the ones that fit in the store.
module asg_front #(
    parameter int MAX_ACTIVITIES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [asg_pkg::FIELD_W-1:0]  s_activity_id,
    input  logic [asg_pkg::FIELD_W-1:0]  s_start_time,
    input  logic [asg_pkg::FIELD_W-1:0]  s_end_time,
    input  logic                         s_last_in_set,
    output logic                         q_valid,
    input  logic                         q_ready,
    output asg_pkg::asg_item_t           q_item
);

    localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);

    logic [CNT_W-1:0] set_cnt_reg;
    logic [CNT_W-1:0] set_cnt_next;
    logic             keep;
    logic             xfer;

    // An activity is kept only while the store still has room.
    assign keep = (set_cnt_reg != CNT_W'(MAX_ACTIVITIES));
    assign xfer = s_valid && s_ready;

    // The front passes straight into the queue.
    assign q_valid           = s_valid;
    assign s_ready           = q_ready;
    assign q_item.keep       = keep;
    assign q_item.last       = s_last_in_set;
    assign q_item.id         = s_activity_id;
    assign q_item.start_time = s_start_time;
    assign q_item.end_time   = s_end_time;

    // Count kept activities of the open set; a closing transaction restarts it.
    always_comb begin
        set_cnt_next = set_cnt_reg;
        if (xfer) begin
            if (s_last_in_set) begin
                set_cnt_next = '0;
            end else if (keep) begin
                set_cnt_next = set_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_cnt_reg <= '0;
        end else begin
            set_cnt_reg <= set_cnt_next;
        end
    end

endmodule

// ===== rtl/asg_fifo.sv =====
// Short queue that decouples the front end from the back end.
module asg_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  asg_pkg::asg_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output asg_pkg::asg_item_t out_item
);

    asg_pkg::asg_item_t entries [asg_pkg::FIFO_DEPTH];

    logic [asg_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [asg_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [asg_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [asg_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [asg_pkg::FIFO_PTR_W:0]   fill_reg;
    logic [asg_pkg::FIFO_PTR_W:0]   fill_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = (fill_reg != (asg_pkg::FIFO_PTR_W + 1)'(asg_pkg::FIFO_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = entries[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + asg_pkg::FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + asg_pkg::FIFO_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (asg_pkg::FIFO_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (asg_pkg::FIFO_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/asg_back.sv =====
// Back end: stores a set, runs the greedy selection passes and sends the chosen ids.
module asg_back #(
    parameter int MAX_ACTIVITIES = 64,
    parameter int TIME_WIDTH     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  asg_pkg::asg_item_t           q_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [asg_pkg::FIELD_W-1:0]  m_chosen_id,
    output logic [asg_pkg::COUNT_W-1:0]  m_chosen_count,
    output logic                         m_last_chosen
);

    localparam int ID_W    = asg_pkg::FIELD_W;
    localparam int KEEP_W  = (TIME_WIDTH < asg_pkg::FIELD_W) ? TIME_WIDTH : asg_pkg::FIELD_W;
    localparam int IDX_W   = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ACTIVITIES + 1);
    localparam int ENTRY_W = ID_W + 2 * KEEP_W;
    localparam int KEY_W   = ENTRY_W + IDX_W;

    // Activity store and chosen-id list.
    logic [ENTRY_W-1:0] act_mem    [MAX_ACTIVITIES];
    logic [ID_W-1:0]    chosen_mem [MAX_ACTIVITIES];

    asg_pkg::asg_back_state_t state_reg;
    asg_pkg::asg_back_state_t state_next;

    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   load_cnt_next;
    logic [CNT_W-1:0]   set_size_reg;
    logic [CNT_W-1:0]   set_size_next;
    logic [IDX_W-1:0]   scan_addr_reg;
    logic [IDX_W-1:0]   scan_addr_next;
    logic               first_pass_reg;
    logic               first_pass_next;
    logic               best_found_reg;
    logic               best_found_next;
    logic [KEY_W-1:0]   best_key_reg;
    logic [KEY_W-1:0]   best_key_next;
    logic [KEY_W-1:0]   anc_key_reg;
    logic [KEY_W-1:0]   anc_key_next;
    logic [CNT_W-1:0]   chosen_total_reg;
    logic [CNT_W-1:0]   chosen_total_next;
    logic [IDX_W-1:0]   emit_idx_reg;
    logic [IDX_W-1:0]   emit_idx_next;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ID_W-1:0]    chosen_rd_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [ID_W-1:0]    m_id_reg;
    logic [ID_W-1:0]    m_id_next;
    logic [CNT_W-1:0]   m_count_reg;
    logic [CNT_W-1:0]   m_count_next;
    logic               m_last_reg;
    logic               m_last_next;

    logic               store_we;
    logic               chosen_we;
    logic               scan_rd;
    logic               load_xfer;
    logic [IDX_W-1:0]   last_addr;
    logic [ID_W-1:0]    rd_id;
    logic [KEEP_W-1:0]  rd_start;
    logic [KEEP_W-1:0]  rd_end;
    logic [KEEP_W-1:0]  anc_start;
    logic [KEY_W-1:0]   cand_key;
    logic               cand_ok;

    // Unpack the entry read last cycle; the store index breaks exact ties.
    assign rd_id     = rd_data_reg[ENTRY_W-1 -: ID_W];
    assign rd_start  = rd_data_reg[2*KEEP_W-1 -: KEEP_W];
    assign rd_end    = rd_data_reg[KEEP_W-1:0];
    assign cand_key  = {rd_start, rd_end, rd_id, rd_idx_reg};
    assign anc_start = anc_key_reg[KEY_W-1 -: KEEP_W];
    assign last_addr = IDX_W'(set_size_reg - CNT_W'(1));

    // A candidate sorts below the anchor and ends in time (later passes) and beats the best.
    assign cand_ok = rd_vld_reg
        && (first_pass_reg || ((cand_key < anc_key_reg) && (rd_end <= anc_start)))
        && (!best_found_reg || (cand_key > best_key_reg));

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asg_pkg::BK_LOAD: begin
                if (q_valid && q_item.last) begin
                    state_next = asg_pkg::BK_SCAN;
                end
            end
            asg_pkg::BK_SCAN: begin
                if (scan_addr_reg == last_addr) begin
                    state_next = asg_pkg::BK_FLUSH;
                end
            end
            asg_pkg::BK_FLUSH: begin
                state_next = asg_pkg::BK_DECIDE;
            end
            asg_pkg::BK_DECIDE: begin
                state_next = best_found_reg ? asg_pkg::BK_SCAN : asg_pkg::BK_EMIT_RD;
            end
            asg_pkg::BK_EMIT_RD: begin
                state_next = asg_pkg::BK_EMIT_LD;
            end
            asg_pkg::BK_EMIT_LD: begin
                state_next = asg_pkg::BK_EMIT_HOLD;
            end
            asg_pkg::BK_EMIT_HOLD: begin
                if (m_ready) begin
                    state_next = m_last_reg ? asg_pkg::BK_LOAD : asg_pkg::BK_EMIT_RD;
                end
            end
            default: begin
                state_next = asg_pkg::BK_LOAD;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        q_ready   = 1'b0;
        scan_rd   = 1'b0;
        chosen_we = 1'b0;
        case (state_reg)
            asg_pkg::BK_LOAD:   q_ready   = 1'b1;
            asg_pkg::BK_SCAN:   scan_rd   = 1'b1;
            asg_pkg::BK_DECIDE: chosen_we = best_found_reg;
            default: begin
                q_ready   = 1'b0;
            end
        endcase
    end

    assign load_xfer = q_valid && q_ready;
    assign store_we  = load_xfer && q_item.keep;

    // Datapath register updates.
    always_comb begin
        load_cnt_next     = load_cnt_reg;
        set_size_next     = set_size_reg;
        scan_addr_next    = scan_addr_reg;
        first_pass_next   = first_pass_reg;
        best_found_next   = best_found_reg;
        best_key_next     = best_key_reg;
        anc_key_next      = anc_key_reg;
        chosen_total_next = chosen_total_reg;
        emit_idx_next     = emit_idx_reg;
        m_valid_next      = m_valid_reg;
        m_id_next         = m_id_reg;
        m_count_next      = m_count_reg;
        m_last_next       = m_last_reg;
        rd_vld_next       = scan_rd;

        // Track the best candidate of the running pass.
        if (cand_ok) begin
            best_found_next = 1'b1;
            best_key_next   = cand_key;
        end

        case (state_reg)
            asg_pkg::BK_LOAD: begin
                if (load_xfer) begin
                    if (q_item.last) begin
                        set_size_next     = load_cnt_reg + CNT_W'(q_item.keep);
                        load_cnt_next     = '0;
                        scan_addr_next    = '0;
                        first_pass_next   = 1'b1;
                        best_found_next   = 1'b0;
                        chosen_total_next = '0;
                    end else if (q_item.keep) begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            asg_pkg::BK_SCAN: begin
                scan_addr_next = scan_addr_reg + IDX_W'(1);
            end
            asg_pkg::BK_DECIDE: begin
                if (best_found_reg) begin
                    // The winner becomes the new anchor; start another pass.
                    chosen_total_next = chosen_total_reg + CNT_W'(1);
                    anc_key_next      = best_key_reg;
                    first_pass_next   = 1'b0;
                    best_found_next   = 1'b0;
                    scan_addr_next    = '0;
                end else begin
                    emit_idx_next = IDX_W'(chosen_total_reg - CNT_W'(1));
                end
            end
            asg_pkg::BK_EMIT_LD: begin
                m_valid_next = 1'b1;
                m_id_next    = chosen_rd_reg;
                m_count_next = chosen_total_reg;
                m_last_next  = (emit_idx_reg == '0);
            end
            asg_pkg::BK_EMIT_HOLD: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (!m_last_reg) begin
                        emit_idx_next = emit_idx_reg - IDX_W'(1);
                    end
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= asg_pkg::BK_LOAD;
            load_cnt_reg     <= '0;
            set_size_reg     <= '0;
            scan_addr_reg    <= '0;
            first_pass_reg   <= 1'b1;
            best_found_reg   <= 1'b0;
            chosen_total_reg <= '0;
            emit_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_last_reg       <= 1'b0;
        end else begin
            state_reg        <= state_next;
            load_cnt_reg     <= load_cnt_next;
            set_size_reg     <= set_size_next;
            scan_addr_reg    <= scan_addr_next;
            first_pass_reg   <= first_pass_next;
            best_found_reg   <= best_found_next;
            chosen_total_reg <= chosen_total_next;
            emit_idx_reg     <= emit_idx_next;
            rd_vld_reg       <= rd_vld_next;
            m_valid_reg      <= m_valid_next;
            m_last_reg       <= m_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        best_key_reg <= best_key_next;
        anc_key_reg  <= anc_key_next;
        m_id_reg     <= m_id_next;
        m_count_reg  <= m_count_next;
        rd_idx_reg   <= scan_addr_reg;
    end

    // Activity store: one write while loading, one registered read while scanning.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            act_mem[load_cnt_reg[IDX_W-1:0]] <= {q_item.id,
                                                 q_item.start_time[KEEP_W-1:0],
                                                 q_item.end_time[KEEP_W-1:0]};
        end
        rd_data_reg <= act_mem[scan_addr_reg];
    end

    // Chosen-id list: written latest start first, read back in reverse.
    always_ff @(posedge aclk) begin
        if (chosen_we) begin
            chosen_mem[chosen_total_reg[IDX_W-1:0]] <= best_key_reg[IDX_W +: ID_W];
        end
        chosen_rd_reg <= chosen_mem[emit_idx_reg];
    end

    assign m_valid        = m_valid_reg;
    assign m_chosen_id    = m_id_reg;
    assign m_chosen_count = asg_pkg::COUNT_W'(m_count_reg);
    assign m_last_chosen  = m_last_reg;

endmodule

// ===== rtl/activity_selection_greedy.sv =====
// Activities load at one per cycle, while the back end loads, via a four-entry queue
// into the store. After the closing activity of a set of n, with c chosen, the back end
// runs c + 1 selection passes, each a scan at one store read per cycle, a flush and a
// decide, then emits each result in read, load and hold states; a full queue stalls input.
// Reset is synchronous and active low: counters, queue and output valid are cleared,
// the activity store and chosen list are not cleared and need no clearing pass.
module activity_selection_greedy #(
    parameter int MAX_ACTIVITIES = 64,
    parameter int TIME_WIDTH     = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [asg_pkg::FIELD_W-1:0]  s_activity_id,
    input  logic [asg_pkg::FIELD_W-1:0]  s_start_time,
    input  logic [asg_pkg::FIELD_W-1:0]  s_end_time,
    input  logic                         s_last_in_set,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [asg_pkg::FIELD_W-1:0]  m_chosen_id,
    output logic [asg_pkg::COUNT_W-1:0]  m_chosen_count,
    output logic                         m_last_chosen
);

    logic               fq_valid;
    logic               fq_ready;
    asg_pkg::asg_item_t fq_item;
    logic               qb_valid;
    logic               qb_ready;
    asg_pkg::asg_item_t qb_item;

    // Front end classifies each incoming activity.
    asg_front #(
        .MAX_ACTIVITIES (MAX_ACTIVITIES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_activity_id (s_activity_id),
        .s_start_time  (s_start_time),
        .s_end_time    (s_end_time),
        .s_last_in_set (s_last_in_set),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    // Queue between front and back.
    asg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // Back end stores, selects and sends results.
    asg_back #(
        .MAX_ACTIVITIES (MAX_ACTIVITIES),
        .TIME_WIDTH     (TIME_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_item         (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chosen_id    (m_chosen_id),
        .m_chosen_count (m_chosen_count),
        .m_last_chosen  (m_last_chosen)
    );

endmodule

// ===== rtl/asg_checker.sv =====
// Port-level checker for the activity selection block and its bind statement.
`include "activity_selection_greedy_macros.svh"

module asg_checker #(
    parameter int MAX_ACTIVITIES = 64
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [asg_pkg::FIELD_W-1:0]  m_chosen_id,
    input logic [asg_pkg::COUNT_W-1:0]  m_chosen_count,
    input logic                         m_last_chosen
);

    // A stalled result transaction keeps its payload.
    `ASG_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_chosen_id) && $stable(m_chosen_count) && $stable(m_last_chosen), "result changed while stalled")

    // Every result reports at least one chosen activity.
    `ASG_ASSERT_NOW(a_count_nonzero, m_valid, m_chosen_count != '0, "zero chosen count")

    // The count never exceeds the store size.
    `ASG_ASSERT_NOW(a_count_bound, m_valid, m_chosen_count <= asg_pkg::COUNT_W'(MAX_ACTIVITIES), "chosen count above store size")

    // A set with one chosen activity ends on its only result.
    `ASG_ASSERT_NOW(a_single_last, m_valid && (m_chosen_count == asg_pkg::COUNT_W'(1)), m_last_chosen, "single result not marked last")

endmodule

bind activity_selection_greedy asg_checker #(
    .MAX_ACTIVITIES (MAX_ACTIVITIES)
) u_asg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_chosen_id    (m_chosen_id),
    .m_chosen_count (m_chosen_count),
    .m_last_chosen  (m_last_chosen)
);
